>>> hw/rtl/sidtoa_pkg.sv
// sidtoa_pkg: shared types and constants for the signed integer to decimal text unit
// holds the bcd digit type, character codes and sequencer states; no dependencies
package sidtoa_pkg;

   typedef logic [3:0] digit_type;
   typedef logic [7:0] char_type;

   localparam int unsigned FRACTION_MAX = 10;
   localparam int unsigned FD_WIDTH     = 4;

   localparam char_type CHAR_ZERO  = 8'h30;
   localparam char_type CHAR_POINT = 8'h2E;
   localparam char_type CHAR_MINUS = 8'h2D;

   localparam digit_type DABBLE_LIMIT  = 4'd5;
   localparam digit_type DABBLE_OFFSET = 4'd3;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CONV  = 6'b000010,
      ST_SKIP  = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_DIGIT = 6'b010000,
      ST_POINT = 6'b100000
   } state_type;

endpackage

>>> hw/rtl/sidtoa_dabble.sv
// sidtoa_dabble: one shift-add-3 step of the binary to bcd conversion
// adjusts every bcd digit and shifts in one binary bit; uses sidtoa_pkg
module sidtoa_dabble #(
   parameter int unsigned SLOTS = 11
) (
   input  logic [SLOTS*4-1:0] bcd_i,
   input  logic               bit_i,
   output logic [SLOTS*4-1:0] bcd_o
);

   logic [SLOTS*4-1:0] adjusted;

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_digit
         sidtoa_pkg::digit_type d;
         assign d = bcd_i[g*4 +: 4];
         assign adjusted[g*4 +: 4] = (d >= sidtoa_pkg::DABBLE_LIMIT) ?
                                     d + sidtoa_pkg::DABBLE_OFFSET : d;
      end
   endgenerate

   assign bcd_o = {adjusted[SLOTS*4-2:0], bit_i};

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii_unit.sv
// signed_int_to_decimal_ascii_unit: formats a signed integer as decimal ascii text
// top level: sequencer, bcd register and character output; uses sidtoa_pkg, sidtoa_dabble
//
// A word is taken when start is high and busy is low. The magnitude goes through a
// bit-serial double-dabble loop over all VALUE_WIDTH bits. The bcd digit slots (eleven
// up to 36 bits) are then walked one per cycle, save while a sign or a point is sent,
// with leading zero slots dropped (at least one digit is kept before the point) and the
// rest sent as characters. Each character is on rsp_character with rsp_strobe high for
// one cycle, and rsp_last is high on the final one: optional '-', the digits, and '.'
// before the last fraction_digits digits. Results cannot be held off, so the receiver
// must take every strobe. Busy falls in the same cycle as the final strobe, and a new
// word can be taken at the end of that cycle, once the previous word has been sent out.
// csr_wdata sets fraction_digits, values above 10 act as 10;
// write it only while busy is low.
module signed_int_to_decimal_ascii_unit #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_character,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [3:0]                    csr_wdata
);

   localparam int unsigned DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int unsigned SLOTS  = (DIGITS > sidtoa_pkg::FRACTION_MAX + 1) ?
                                    DIGITS : sidtoa_pkg::FRACTION_MAX + 1;
   localparam int unsigned IDXW   = $clog2(SLOTS);
   localparam int unsigned CNTW   = $clog2(VALUE_WIDTH);
   localparam int unsigned CMPW   = (IDXW > sidtoa_pkg::FD_WIDTH) ? IDXW : sidtoa_pkg::FD_WIDTH;

   sidtoa_pkg::state_type  state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [SLOTS*4-1:0]     bcd_ff, bcd_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic [IDXW-1:0]        idx_ff, idx_in;
   logic                   neg_ff, neg_in;
   logic [3:0]             fd_ff;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   sidtoa_pkg::char_type   rsp_character_ff, rsp_character_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] mag_abs;
   logic [SLOTS*4-1:0]     bcd_step;
   logic [SLOTS*4-1:0]     bcd_shift;
   sidtoa_pkg::digit_type  top_digit;
   logic [3:0]             fd_sat;
   logic [CMPW-1:0]        idx_ext;
   logic [CMPW-1:0]        fd_ext;

   sidtoa_dabble #(
      .SLOTS (SLOTS)
   ) u_dabble (
      .bcd_i (bcd_ff),
      .bit_i (mag_ff[VALUE_WIDTH-1]),
      .bcd_o (bcd_step)
   );

   assign raw       = req_value;
   assign mag_abs   = raw[VALUE_WIDTH-1] ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
   assign top_digit = bcd_ff[SLOTS*4-1 -: 4];
   assign bcd_shift = {bcd_ff[SLOTS*4-5:0], 4'b0000};
   assign fd_sat    = (fd_ff > 4'(sidtoa_pkg::FRACTION_MAX)) ?
                      4'(sidtoa_pkg::FRACTION_MAX) : fd_ff;
   assign idx_ext   = CMPW'(idx_ff);
   assign fd_ext    = CMPW'(fd_sat);

   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      bcd_in           = bcd_ff;
      cnt_in           = cnt_ff;
      idx_in           = idx_ff;
      neg_in           = neg_ff;
      rsp_strobe_in    = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = 1'b0;
      unique case (state_ff)
         sidtoa_pkg::ST_IDLE: begin
            if (start) begin
               mag_in   = mag_abs;
               neg_in   = raw[VALUE_WIDTH-1];
               bcd_in   = '0;
               cnt_in   = CNTW'(VALUE_WIDTH - 1);
               state_in = sidtoa_pkg::ST_CONV;
            end
         end
         sidtoa_pkg::ST_CONV: begin
            bcd_in = bcd_step;
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               idx_in   = IDXW'(SLOTS - 1);
               state_in = sidtoa_pkg::ST_SKIP;
            end
         end
         sidtoa_pkg::ST_SKIP: begin
            if (top_digit == '0 && idx_ext > fd_ext && idx_ff != '0) begin
               bcd_in = bcd_shift;
               idx_in = idx_ff - 1'b1;
            end else begin
               state_in = neg_ff ? sidtoa_pkg::ST_SIGN : sidtoa_pkg::ST_DIGIT;
            end
         end
         sidtoa_pkg::ST_SIGN: begin
            rsp_strobe_in    = 1'b1;
            rsp_character_in = sidtoa_pkg::CHAR_MINUS;
            state_in         = sidtoa_pkg::ST_DIGIT;
         end
         sidtoa_pkg::ST_DIGIT: begin
            rsp_strobe_in    = 1'b1;
            rsp_character_in = sidtoa_pkg::CHAR_ZERO + {4'b0000, top_digit};
            rsp_last_in      = (idx_ff == '0);
            bcd_in           = bcd_shift;
            idx_in           = idx_ff - 1'b1;
            priority if (fd_sat != '0 && idx_ext == fd_ext) begin
               state_in = sidtoa_pkg::ST_POINT;
            end else if (idx_ff == '0) begin
               state_in = sidtoa_pkg::ST_IDLE;
            end
         end
         sidtoa_pkg::ST_POINT: begin
            rsp_strobe_in    = 1'b1;
            rsp_character_in = sidtoa_pkg::CHAR_POINT;
            state_in         = sidtoa_pkg::ST_DIGIT;
         end
         default: begin
            state_in = sidtoa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sidtoa_pkg::ST_IDLE;
         fd_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
         if (csr_we) begin
            fd_ff <= csr_wdata;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      bcd_ff           <= bcd_in;
      cnt_ff           <= cnt_in;
      idx_ff           <= idx_in;
      neg_ff           <= neg_in;
      rsp_character_ff <= rsp_character_in;
   end

   assign busy          = (state_ff != sidtoa_pkg::ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> tb/sv/sidtoa_checker.sv
`timescale 1ns / 1ps
// sidtoa_checker: watches the request, result and register ports of the decimal text unit,
// predicts the ascii string of each accepted word and compares every character in order
// depends on sidtoa_pkg for the character codes, digit type and fraction limit
module sidtoa_checker #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   input  logic                                rsp_strobe,
   input  logic [7:0]                          rsp_character,
   input  logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [sidtoa_pkg::FD_WIDTH-1:0]     csr_wdata,
   output int                                  mismatch_count,
   output int                                  chars_pending
);

   localparam int unsigned RADIX = 10;

   typedef struct packed {
      sidtoa_pkg::char_type character;
      logic                 last;
   } text_char_type;

   text_char_type                   expected_text[$];
   text_char_type                   oldest;
   logic [sidtoa_pkg::FD_WIDTH-1:0] fraction_setting;

   task automatic queue_decimal_text(input logic [VALUE_WIDTH-1:0] raw,
                                     input int unsigned setting);
      sidtoa_pkg::digit_type  digits[$];
      sidtoa_pkg::char_type   line[$];
      logic [VALUE_WIDTH-1:0] magnitude;
      longint unsigned        rest;
      int                     places;
      magnitude = raw[VALUE_WIDTH-1] ? ~raw + 1'b1 : raw;
      rest      = magnitude;
      places    = (setting > sidtoa_pkg::FRACTION_MAX) ? sidtoa_pkg::FRACTION_MAX : setting;
      do begin
         digits.push_back(sidtoa_pkg::digit_type'(rest % RADIX));
         rest = rest / RADIX;
      end while (rest != 0);
      // pad with leading zeros so a digit stands before the point
      while (places > 0 && digits.size() < places + 1) digits.push_back('0);
      if (raw[VALUE_WIDTH-1]) line.push_back(sidtoa_pkg::CHAR_MINUS);
      for (int i = digits.size() - 1; i >= 0; i--) begin
         line.push_back(sidtoa_pkg::CHAR_ZERO + sidtoa_pkg::char_type'(digits[i]));
         if (places > 0 && i == places) line.push_back(sidtoa_pkg::CHAR_POINT);
      end
      foreach (line[j]) expected_text.push_back(text_char_type'{line[j], j == line.size() - 1});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fraction_setting = '0;
         expected_text.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_text.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected character %h last %b", $time, rsp_character,
                           rsp_last);
            end else begin
               oldest = expected_text.pop_front();
               if (rsp_character !== oldest.character || rsp_last !== oldest.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected character %h last %b, got %h last %b", $time,
                              oldest.character, oldest.last, rsp_character, rsp_last);
               end
            end
         end
         if (start && !busy) queue_decimal_text(req_value, fraction_setting);
         if (csr_we) fraction_setting = csr_wdata;
      end
      chars_pending = expected_text.size();
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: drives signed words and fraction digit settings into the decimal text unit
// in paced bursts and gives the verdict; depends on sidtoa_checker and the unit itself
module testbench;

   localparam int unsigned VALUE_WIDTH    = 32;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          PHASE_COUNT    = 11;
   localparam int          PHASE_WORDS    = 40;
   localparam int unsigned PHASE_SETTING[PHASE_COUNT] = '{1, 0, 10, 15, 4, 7, 11, 2, 9, 3, 6};

   logic                          clock;
   logic                          reset     = 1'b1;
   logic                          start     = 1'b0;
   logic                          busy;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_strobe;
   logic [7:0]                    rsp_character;
   logic                          rsp_last;
   logic                          csr_we    = 1'b0;
   logic [3:0]                    csr_wdata = '0;
   int                            mismatch_count;
   int                            chars_pending;
   int                            quiet_cycles = 0;
   int                            burst_left   = 0;

   signed_int_to_decimal_ascii_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata)
   );

   sidtoa_checker #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .mismatch_count(mismatch_count),
      .chars_pending (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic signed [VALUE_WIDTH-1:0] word);
      req_value <= word;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_paced(input logic signed [VALUE_WIDTH-1:0] word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      send_word(word);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (chars_pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_fraction_digits(input logic [3:0] setting);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= setting;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [VALUE_WIDTH-1:0] random_word();
      logic [VALUE_WIDTH-1:0] word;
      longint unsigned        power;
      word  = '0;
      power = 1;
      case ($urandom_range(0, 5))
         0, 1: word = $urandom;
         2: word = $urandom_range(0, 120);
         3: word = $urandom >> $urandom_range(0, 31);
         4: begin
            repeat ($urandom_range(0, 9)) power = power * 10;
            word = power[VALUE_WIDTH-1:0] - $urandom_range(0, 1);
         end
         default: begin
            case ($urandom_range(0, 3))
               0: word = 32'h7FFF_FFFF;
               1: word = 32'h8000_0000;
               2: word = 32'h8000_0001;
               default: word = '0;
            endcase
         end
      endcase
      if ($urandom_range(0, 1) == 1) word = -word;
      return word;
   endfunction

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no point after reset
      send_paced(32'sd0);
      send_paced(32'sd1);
      send_paced(-32'sd1);
      send_paced(32'sd9);
      send_paced(32'sd10);
      send_paced(-32'sd10);
      send_paced(32'sh7FFF_FFFF);
      send_paced(32'sh8000_0000);
      send_paced(32'sh5555_5555);
      send_paced(32'shAAAA_AAAA);

      set_fraction_digits(4'd2);
      send_paced(32'sd5);
      send_paced(-32'sd5);
      send_paced(32'sd0);
      send_paced(32'sd123);
      send_paced(32'sh8000_0000);

      // settings above ten saturate
      set_fraction_digits(4'd13);
      send_paced(32'sd0);
      send_paced(32'sd7);
      send_paced(32'sh7FFF_FFFF);
      send_paced(32'sh8000_0000);
      send_paced(-32'sd1);

      set_fraction_digits(4'd10);
      send_paced(32'sd1234567890);
      send_paced(-32'sd42);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         set_fraction_digits(PHASE_SETTING[phase][3:0]);
         repeat (PHASE_WORDS) send_paced(random_word());
      end

      wait_drained();
      repeat (64) @(negedge clock);
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/sidtoa_pkg.sv
hw/rtl/sidtoa_dabble.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
tb/sv/sidtoa_checker.sv
tb/sv/testbench.sv
